// ===== src/plane_handle_quad_projection_core_assert.svh =====
// Assertion macros for the plane handle projection core.
// Used by the port checker; depends on clk and arst_n in the scope of use.
`ifndef PLANE_HANDLE_QUAD_PROJECTION_CORE_ASSERT_SVH
`define PLANE_HANDLE_QUAD_PROJECTION_CORE_ASSERT_SVH

// clocked assertion, off while reset is asserted
`define PHQP_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked next-cycle implication, off while reset is asserted
`define PHQP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/phqp_pkg.sv =====
// Shared constants, register indexes and saturation helpers for the
// plane handle projection core. No dependencies.
package phqp_pkg;

	localparam int CORNER_COUNT = 4;
	localparam int S_DATA_W     = 328;
	localparam int M_DATA_W     = CORNER_COUNT * 64;
	localparam int ADDR_W       = 5;

	localparam logic signed [31:0] EPS_Q  = 32'sd6;
	localparam logic [63:0]        EPS_SQ = 64'd42;

	localparam logic [2:0] REG_VP_LEFT   = 3'd0;
	localparam logic [2:0] REG_VP_TOP    = 3'd1;
	localparam logic [2:0] REG_VP_WIDTH  = 3'd2;
	localparam logic [2:0] REG_VP_HEIGHT = 3'd3;
	localparam logic [2:0] REG_INNER     = 3'd4;
	localparam logic [2:0] REG_OUTER     = 3'd5;

	localparam logic signed [31:0] INNER_RST = 32'sd13107;
	localparam logic signed [31:0] OUTER_RST = 32'sd39322;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_PROJECT = 1'b1;

	function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
		if (x > 68'sd2147483647)
			return 32'sh7fffffff;
		else if (x < -68'sd2147483648)
			return 32'sh80000000;
		else
			return x[31:0];
	endfunction

	function automatic logic signed [30:0] sat30(input logic signed [32:0] x);
		if (x > 33'sd1073741823)
			return 31'sh3fffffff;
		else if (x < -33'sd1073741824)
			return 31'sh40000000;
		else
			return x[30:0];
	endfunction

endpackage

// ===== src/plane_handle_quad_projection_core.sv =====
// Plane handle projection core: top level with matrix store, sequencer,
// shared multiplier, shared divider and square root stepper. Uses phqp_pkg.
//
// A load item (tuser 0) writes one matrix entry and leaves the core idle.
// While a project item (tuser 1) is processed, s_axis_tready stays low:
// eighteen divisions of 48 steps each on the single restoring divider,
// 178 passes through the one 34x34 multiplier (registered matrix read,
// multiply, accumulate) and two 32-step square roots. Exactly one result
// per project item is presented on the m_axis side; the result register
// lets the next item start while it waits. Configuration is written through
// the APB port while the core is idle; the user must keep to this, the core does not enforce it.
module plane_handle_quad_projection_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// element_index[4:0], scalar_value[36:5], origin_x/y/z[132:37],
	// axis_u_x/y/z[228:133], axis_v_x/y/z[324:229], zero fill[327:325]
	input  logic [phqp_pkg::S_DATA_W-1:0] s_axis_tdata,
	input  logic                        s_axis_tuser, // op
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// corner0_x, corner0_y, corner1_x ... corner3_y, 32 bits each from bit 0
	output logic [phqp_pkg::M_DATA_W-1:0] m_axis_tdata,
	output logic                        m_axis_tuser, // ok
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [phqp_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	typedef enum logic [3:0] {
		S_IDLE, S_SQ, S_CHECK, S_SQRT, S_NDIV, S_KUV, S_PT, S_VIEW,
		S_PROJ, S_WCHK, S_CDIV, S_VP, S_EDGE, S_AREA, S_DONE
	} state_t;

	state_t state_q;
	logic [3:0] idx_q;
	logic [1:0] ph_q;
	logic [1:0] k_q;
	logic       vsel_q;
	logic       ok_q;

	// configuration
	logic signed [31:0] vp_left_q, vp_top_q, inner_q, outer_q;
	logic [30:0]        vp_w_q, vp_h_q;

	// item and working registers
	logic signed [31:0] lh_q;
	logic signed [31:0] org_q [3];
	logic signed [31:0] au_q [3];
	logic signed [31:0] av_q [3];
	logic signed [17:0] nu_q [3];
	logic signed [17:0] nv_q [3];
	logic signed [31:0] ku_q, kv_q;
	logic signed [31:0] pt_q [3];
	logic signed [31:0] ve_q [4];
	logic signed [31:0] cc_q [4];
	logic signed [31:0] nx_q, ny_q;
	logic signed [31:0] cx_q [phqp_pkg::CORNER_COUNT];
	logic signed [31:0] cy_q [phqp_pkg::CORNER_COUNT];
	logic signed [30:0] ed_q [6];
	logic [63:0]        sq_u_q, sq_v_q;
	logic [31:0]        len_q;
	logic signed [67:0] acc_q, prod_q;

	// square root stepper
	logic [63:0] sqr_rem_q, sqr_res_q, sqr_bit_q;
	logic [64:0] sqr_sum;
	logic        sqr_ge;
	logic [63:0] sqr_res_nx;

	// divider
	logic [47:0] div_num_q, div_quo_q;
	logic [31:0] div_den_q, div_rem_q;
	logic        div_neg_q;
	logic [5:0]  div_cnt_q;
	logic [32:0] div_sh;
	logic        div_ge;
	logic [32:0] div_rem_nx;
	logic signed [31:0] div_ld_num;
	logic signed [32:0] div_ld_den;
	logic [32:0] div_num_abs, div_den_abs;
	logic signed [48:0] div_q;

	// multiplier
	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] mul_p;
	logic signed [67:0] prod_sh16, prod_sh17, acc_sum;

	// matrix store
	logic [31:0] mat_mem [32];
	logic [31:0] mat_rd_q;
	logic [4:0]  mat_addr;

	// output register
	logic                          m_valid_q, m_user_q;
	logic [phqp_pkg::M_DATA_W-1:0] m_data_q;

	logic s_take, mac_st, div_st;
	logic [phqp_pkg::M_DATA_W-1:0] pack;

	assign s_axis_tready = (state_q == S_IDLE);
	assign s_take        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign pready        = 1'b1;

	assign mac_st = state_q inside {S_SQ, S_KUV, S_PT, S_VIEW, S_PROJ, S_VP, S_AREA};
	assign div_st = state_q inside {S_NDIV, S_CDIV};

	// APB
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_left_q <= '0;
			vp_top_q  <= '0;
			vp_w_q    <= '0;
			vp_h_q    <= '0;
			inner_q   <= phqp_pkg::INNER_RST;
			outer_q   <= phqp_pkg::OUTER_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				phqp_pkg::REG_VP_LEFT:   vp_left_q <= pwdata;
				phqp_pkg::REG_VP_TOP:    vp_top_q  <= pwdata;
				phqp_pkg::REG_VP_WIDTH:  vp_w_q    <= pwdata[30:0];
				phqp_pkg::REG_VP_HEIGHT: vp_h_q    <= pwdata[30:0];
				phqp_pkg::REG_INNER:     inner_q   <= pwdata;
				phqp_pkg::REG_OUTER:     outer_q   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			phqp_pkg::REG_VP_LEFT:   prdata = vp_left_q;
			phqp_pkg::REG_VP_TOP:    prdata = vp_top_q;
			phqp_pkg::REG_VP_WIDTH:  prdata = {1'b0, vp_w_q};
			phqp_pkg::REG_VP_HEIGHT: prdata = {1'b0, vp_h_q};
			phqp_pkg::REG_INNER:     prdata = inner_q;
			phqp_pkg::REG_OUTER:     prdata = outer_q;
			default:                 prdata = '0;
		endcase
	end

	// matrix store, view at 0..15 and projection at 16..31, column-major
	assign mat_addr = {state_q == S_PROJ, idx_q[1:0], idx_q[3:2]};

	always_ff @(posedge clk) begin
		if (s_take && s_axis_tuser == phqp_pkg::OP_LOAD)
			mat_mem[s_axis_tdata[4:0]] <= s_axis_tdata[36:5];
		mat_rd_q <= mat_mem[mat_addr];
	end

	// multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQ: begin
				case (idx_q)
					4'd0:    mul_a = 34'(au_q[0]);
					4'd1:    mul_a = 34'(au_q[1]);
					4'd2:    mul_a = 34'(au_q[2]);
					4'd3:    mul_a = 34'(av_q[0]);
					4'd4:    mul_a = 34'(av_q[1]);
					default: mul_a = 34'(av_q[2]);
				endcase
				mul_b = mul_a;
			end
			S_KUV: begin
				mul_a = 34'(lh_q);
				if (idx_q[0])
					mul_b = (k_q[1]) ? 34'(outer_q) : 34'(inner_q);
				else
					mul_b = (k_q == 2'd1 || k_q == 2'd2) ? 34'(outer_q) : 34'(inner_q);
			end
			S_PT: begin
				if (idx_q[0]) begin
					mul_a = 34'(nv_q[idx_q[2:1]]);
					mul_b = 34'(kv_q);
				end else begin
					mul_a = 34'(nu_q[idx_q[2:1]]);
					mul_b = 34'(ku_q);
				end
			end
			S_VIEW: begin
				mul_a = 34'(signed'(mat_rd_q));
				if (idx_q[1:0] == 2'd3)
					mul_b = 34'sd65536;
				else
					mul_b = 34'(pt_q[idx_q[1:0]]);
			end
			S_PROJ: begin
				mul_a = 34'(signed'(mat_rd_q));
				mul_b = 34'(ve_q[idx_q[1:0]]);
			end
			S_VP: begin
				if (idx_q[0]) begin
					mul_a = 34'sd65536 - 34'(ny_q);
					mul_b = signed'({3'b000, vp_h_q});
				end else begin
					mul_a = 34'(nx_q) + 34'sd65536;
					mul_b = signed'({3'b000, vp_w_q});
				end
			end
			S_AREA: begin
				case (idx_q[1:0])
					2'd0:    begin mul_a = 34'(ed_q[0]); mul_b = 34'(ed_q[3]); end
					2'd1:    begin mul_a = 34'(ed_q[1]); mul_b = 34'(ed_q[2]); end
					2'd2:    begin mul_a = 34'(ed_q[2]); mul_b = 34'(ed_q[5]); end
					default: begin mul_a = 34'(ed_q[3]); mul_b = 34'(ed_q[4]); end
				endcase
			end
			default: ;
		endcase
	end

	assign mul_p     = 68'(mul_a) * 68'(mul_b);
	assign prod_sh16 = prod_q >>> 16;
	assign prod_sh17 = prod_q >>> 17;
	assign acc_sum   = acc_q + prod_sh16;

	// square root step
	assign sqr_sum    = {1'b0, sqr_res_q} + {1'b0, sqr_bit_q};
	assign sqr_ge     = {1'b0, sqr_rem_q} >= sqr_sum;
	assign sqr_res_nx = sqr_ge ? ((sqr_res_q >> 1) + sqr_bit_q) : (sqr_res_q >> 1);

	// divider load operands and step
	always_comb begin
		if (state_q == S_NDIV) begin
			div_ld_num = vsel_q ? av_q[idx_q[1:0]] : au_q[idx_q[1:0]];
			div_ld_den = signed'({1'b0, len_q});
		end else begin
			case (idx_q[1:0])
				2'd0:    div_ld_num = cc_q[2];
				2'd1:    div_ld_num = cc_q[0];
				default: div_ld_num = cc_q[1];
			endcase
			div_ld_den = 33'(cc_q[3]);
		end
	end

	assign div_num_abs = div_ld_num[31] ? -33'(div_ld_num) : 33'(div_ld_num);
	assign div_den_abs = div_ld_den[32] ? -div_ld_den : div_ld_den;
	assign div_sh      = {div_rem_q, div_num_q[47]};
	assign div_ge      = div_sh >= {1'b0, div_den_q};
	assign div_rem_nx  = div_ge ? (div_sh - {1'b0, div_den_q}) : div_sh;
	assign div_q       = div_neg_q ? -signed'({1'b0, div_quo_q}) : signed'({1'b0, div_quo_q});

	always_comb begin
		for (int k = 0; k < phqp_pkg::CORNER_COUNT; k++) begin
			pack[64*k +: 32]      = cx_q[k];
			pack[64*k + 32 +: 32] = cy_q[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			idx_q     <= '0;
			ph_q      <= '0;
			k_q       <= '0;
			vsel_q    <= 1'b0;
			ok_q      <= 1'b0;
			m_valid_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			if (m_valid_q && m_axis_tready)
				m_valid_q <= 1'b0;

			// shared multiply pass: read, multiply, accumulate
			if (mac_st) begin
				case (ph_q)
					2'd0:    ph_q <= 2'd1;
					2'd1:    begin prod_q <= mul_p; ph_q <= 2'd2; end
					default: ph_q <= 2'd0;
				endcase
			end

			// shared division pass: load, 48 steps, consume
			if (div_st) begin
				case (ph_q)
					2'd0: begin
						div_num_q <= {div_num_abs[31:0], 16'h0000};
						div_den_q <= div_den_abs[31:0];
						div_rem_q <= '0;
						div_quo_q <= '0;
						div_neg_q <= div_ld_num[31] ^ div_ld_den[32];
						div_cnt_q <= '0;
						ph_q      <= 2'd1;
					end
					2'd1: begin
						div_rem_q <= div_rem_nx[31:0];
						div_quo_q <= {div_quo_q[46:0], div_ge};
						div_num_q <= {div_num_q[46:0], 1'b0};
						div_cnt_q <= div_cnt_q + 6'd1;
						if (div_cnt_q == 6'd47)
							ph_q <= 2'd2;
					end
					default: ph_q <= 2'd0;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (s_take && s_axis_tuser == phqp_pkg::OP_PROJECT) begin
						lh_q     <= s_axis_tdata[36:5];
						org_q[0] <= s_axis_tdata[68:37];
						org_q[1] <= s_axis_tdata[100:69];
						org_q[2] <= s_axis_tdata[132:101];
						au_q[0]  <= s_axis_tdata[164:133];
						au_q[1]  <= s_axis_tdata[196:165];
						au_q[2]  <= s_axis_tdata[228:197];
						av_q[0]  <= s_axis_tdata[260:229];
						av_q[1]  <= s_axis_tdata[292:261];
						av_q[2]  <= s_axis_tdata[324:293];
						ok_q     <= 1'b1;
						acc_q    <= '0;
						idx_q    <= '0;
						ph_q     <= '0;
						state_q  <= S_SQ;
					end
				end
				S_SQ: begin
					if (ph_q == 2'd2) begin
						idx_q <= idx_q + 4'd1;
						acc_q <= acc_q + prod_q;
						if (idx_q == 4'd2) begin
							sq_u_q <= acc_q[63:0] + prod_q[63:0];
							acc_q  <= '0;
						end else if (idx_q == 4'd5) begin
							sq_v_q  <= acc_q[63:0] + prod_q[63:0];
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (lh_q <= phqp_pkg::EPS_Q || inner_q[31] || outer_q <= inner_q ||
					    sq_u_q <= phqp_pkg::EPS_SQ || sq_v_q <= phqp_pkg::EPS_SQ) begin
						ok_q    <= 1'b0;
						state_q <= S_DONE;
					end else begin
						sqr_rem_q <= sq_u_q;
						sqr_res_q <= '0;
						sqr_bit_q <= 64'd1 << 62;
						vsel_q    <= 1'b0;
						state_q   <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sqr_ge)
						sqr_rem_q <= sqr_rem_q - sqr_sum[63:0];
					sqr_res_q <= sqr_res_nx;
					sqr_bit_q <= sqr_bit_q >> 2;
					if (sqr_bit_q[0]) begin
						len_q   <= sqr_res_nx[31:0];
						idx_q   <= '0;
						ph_q    <= '0;
						state_q <= S_NDIV;
					end
				end
				S_NDIV: begin
					if (ph_q == 2'd2) begin
						if (vsel_q)
							nv_q[idx_q[1:0]] <= div_q[17:0];
						else
							nu_q[idx_q[1:0]] <= div_q[17:0];
						idx_q <= idx_q + 4'd1;
						if (idx_q == 4'd2) begin
							idx_q <= '0;
							if (!vsel_q) begin
								vsel_q    <= 1'b1;
								sqr_rem_q <= sq_v_q;
								sqr_res_q <= '0;
								sqr_bit_q <= 64'd1 << 62;
								state_q   <= S_SQRT;
							end else begin
								k_q     <= '0;
								state_q <= S_KUV;
							end
						end
					end
				end
				S_KUV: begin
					if (ph_q == 2'd2) begin
						idx_q <= idx_q + 4'd1;
						if (idx_q[0]) begin
							kv_q    <= phqp_pkg::sat32(prod_sh16);
							idx_q   <= '0;
							state_q <= S_PT;
						end else begin
							ku_q <= phqp_pkg::sat32(prod_sh16);
						end
					end
				end
				S_PT: begin
					if (ph_q == 2'd2) begin
						idx_q <= idx_q + 4'd1;
						if (idx_q[0])
							pt_q[idx_q[2:1]] <= phqp_pkg::sat32(acc_sum);
						else
							acc_q <= 68'(org_q[idx_q[2:1]]) + prod_sh16;
						if (idx_q == 4'd5) begin
							idx_q   <= '0;
							state_q <= S_VIEW;
						end
					end
				end
				S_VIEW, S_PROJ: begin
					if (ph_q == 2'd2) begin
						idx_q <= idx_q + 4'd1;
						if (idx_q[1:0] == 2'd0)
							acc_q <= prod_sh16;
						else
							acc_q <= acc_sum;
						if (idx_q[1:0] == 2'd3) begin
							if (state_q == S_VIEW)
								ve_q[idx_q[3:2]] <= phqp_pkg::sat32(acc_sum);
							else
								cc_q[idx_q[3:2]] <= phqp_pkg::sat32(acc_sum);
						end
						if (idx_q == 4'd15)
							state_q <= (state_q == S_VIEW) ? S_PROJ : S_WCHK;
					end
				end
				S_WCHK: begin
					idx_q <= '0;
					ph_q  <= '0;
					if (cc_q[3] <= phqp_pkg::EPS_Q && cc_q[3] >= -phqp_pkg::EPS_Q) begin
						ok_q    <= 1'b0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_CDIV;
					end
				end
				S_CDIV: begin
					if (ph_q == 2'd2) begin
						idx_q <= idx_q + 4'd1;
						case (idx_q[1:0])
							2'd0: begin
								// depth outside 0..1 drops the quad
								if (div_q < 49'sd0 || div_q > 49'sd65536) begin
									ok_q    <= 1'b0;
									state_q <= S_DONE;
								end
							end
							2'd1: nx_q <= phqp_pkg::sat32(68'(div_q));
							default: begin
								ny_q    <= phqp_pkg::sat32(68'(div_q));
								idx_q   <= '0;
								state_q <= S_VP;
							end
						endcase
					end
				end
				S_VP: begin
					if (ph_q == 2'd2) begin
						idx_q <= idx_q + 4'd1;
						if (idx_q[0]) begin
							cy_q[k_q] <= phqp_pkg::sat32(68'(vp_top_q) + prod_sh17);
							idx_q     <= '0;
							k_q       <= k_q + 2'd1;
							state_q   <= (k_q == 2'd3) ? S_EDGE : S_KUV;
						end else begin
							cx_q[k_q] <= phqp_pkg::sat32(68'(vp_left_q) + prod_sh17);
						end
					end
				end
				S_EDGE: begin
					for (int e = 0; e < 3; e++) begin
						ed_q[2*e]   <= phqp_pkg::sat30(33'(cx_q[e+1]) - 33'(cx_q[0]));
						ed_q[2*e+1] <= phqp_pkg::sat30(33'(cy_q[e+1]) - 33'(cy_q[0]));
					end
					acc_q   <= '0;
					idx_q   <= '0;
					ph_q    <= '0;
					state_q <= S_AREA;
				end
				S_AREA: begin
					if (ph_q == 2'd2) begin
						idx_q <= idx_q + 4'd1;
						acc_q <= idx_q[0] ? (acc_q - prod_q) : (acc_q + prod_q);
						if (idx_q == 4'd3) begin
							if ((acc_q - prod_q) < 68'sh200000000 &&
							    (acc_q - prod_q) > -68'sh200000000)
								ok_q <= 1'b0;
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_user_q  <= ok_q;
						m_data_q  <= ok_q ? pack : '0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== src/phqp_checker.sv =====
// Port checker for the plane handle projection core, bound to the top level.
// Depends on plane_handle_quad_projection_core_assert.svh.
`include "plane_handle_quad_projection_core_assert.svh"

module phqp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          s_axis_tuser,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [phqp_pkg::M_DATA_W-1:0] m_axis_tdata,
	input logic                          m_axis_tuser
);

	`PHQP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed while stalled")
	`PHQP_ASSERT_CLK(a_fail_zero, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0, "failed quad carries non-zero corners")
	`PHQP_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser, !s_axis_tready, "project transfer did not make the core busy")

endmodule

bind plane_handle_quad_projection_core phqp_checker u_phqp_checker (.*);
